// ----- rtl/sbbc_pkg.sv -----
// shared types and constants for the sprite bounding box collision block
`default_nettype none

package sbbc_pkg;

  // field widths
  localparam int SLOT_W  = 4;
  localparam int CLASS_W = 3;
  localparam int CFG_W   = 5;
  localparam int CFG_A_W = 2;
  localparam int CMD_W   = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PLACE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_CLASS1_START = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_CLASS2_START = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_CLASS3_START = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_CLASS4_START = 2'd3;

  // configuration reset values
  localparam logic [CFG_W-1:0] CLASS1_RESET = 5'd1;
  localparam logic [CFG_W-1:0] CLASS2_RESET = 5'd8;
  localparam logic [CFG_W-1:0] CLASS3_RESET = 5'd14;
  localparam logic [CFG_W-1:0] CLASS4_RESET = 5'd15;

  // slot index space reachable through the slot field
  localparam int SLOT_SPACE = 16;

  // one stored sprite box, x held in 4-pixel units
  typedef struct packed {
    logic [7:0] x4;
    logic [8:0] y;
    logic [5:0] w;
    logic [7:0] h;
    logic [3:0] bx;
    logic [3:0] by;
  } box_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic wr_place;
    logic wr_remove;
    logic start_query;
    logic read_q;
    logic load_q;
    logic step;
    logic take_hit;
    logic emit_pend;
    logic emit_last;
    logic emit_none;
  } ctl_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic slot_ok;
    logic cand;
    logic idx_last;
    logic pend_valid;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/sbbc_ctrl.sv -----
// controller state machine: command decode, query scan sequencing, result emission
`default_nettype none

module sbbc_ctrl (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [sbbc_pkg::CMD_W-1:0]  command,
  input  wire  sbbc_pkg::stat_t       stat,
  output sbbc_pkg::ctl_t              ctl
);
  import sbbc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_QRD  = 3'd1;
  localparam logic [2:0] S_QLD  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;
  logic       stall;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // a second hit cannot be taken while the older one still waits for the output register
  assign stall    = stat.cand && stat.pend_valid && !stat.out_free;

  // next state and command decode
  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && stat.slot_ok) begin
          unique case (command)
            CMD_PLACE:  ctl.wr_place = 1'b1;
            CMD_REMOVE: ctl.wr_remove = 1'b1;
            CMD_QUERY: begin
              ctl.start_query = 1'b1;
              state_next      = S_QRD;
            end
            default: ;
          endcase
        end
      end
      S_QRD: begin
        ctl.read_q = 1'b1;
        state_next = S_QLD;
      end
      S_QLD: begin
        ctl.load_q = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!stall) begin
          ctl.step      = 1'b1;
          ctl.take_hit  = stat.cand;
          ctl.emit_pend = stat.cand && stat.pend_valid;
          if (stat.idx_last) begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          ctl.emit_last = stat.pend_valid;
          ctl.emit_none = !stat.pend_valid;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sbbc_datapath.sv -----
// datapath: slot table, class boundaries, box compare, pending hit and output register
`default_nettype none

module sbbc_datapath #(
  parameter int NUM_SLOTS   = 16,
  parameter int NUM_CLASSES = 5
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire  sbbc_pkg::ctl_t          ctl,
  output sbbc_pkg::stat_t               stat,
  input  wire                           cfg_we,
  input  wire  [sbbc_pkg::CFG_A_W-1:0]  cfg_addr,
  input  wire  [sbbc_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire  [sbbc_pkg::SLOT_W-1:0]   slot,
  input  wire  [9:0]                    pos_x,
  input  wire  [8:0]                    pos_y,
  input  wire  [5:0]                    width_units,
  input  wire  [7:0]                    height_rows,
  input  wire  [3:0]                    border_x,
  input  wire  [3:0]                    border_y,
  input  wire                           out_ready,
  output logic                          out_valid,
  output logic [sbbc_pkg::SLOT_W-1:0]   hit_slot,
  output logic [sbbc_pkg::CLASS_W-1:0]  hit_class,
  output logic                          none_found,
  output logic                          last
);
  import sbbc_pkg::*;

  localparam int ACT   = (NUM_SLOTS < SLOT_SPACE) ? NUM_SLOTS : SLOT_SPACE;
  localparam int IDX_W = $clog2(ACT);
  localparam int CW    = 13;
  localparam logic [CLASS_W-1:0] MAX_CLASS = CLASS_W'(NUM_CLASSES - 1);
  localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(ACT - 1);

  // class boundary registers
  logic [CFG_W-1:0] c1_start;
  logic [CFG_W-1:0] c2_start;
  logic [CFG_W-1:0] c3_start;
  logic [CFG_W-1:0] c4_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_start <= CLASS1_RESET;
      c2_start <= CLASS2_RESET;
      c3_start <= CLASS3_RESET;
      c4_start <= CLASS4_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CLASS1_START: c1_start <= cfg_wdata;
        REG_CLASS2_START: c2_start <= cfg_wdata;
        REG_CLASS3_START: c3_start <= cfg_wdata;
        REG_CLASS4_START: c4_start <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // slot table memory and enable bits
  box_t             mem [ACT];
  box_t             rdata;
  box_t             wbox;
  logic [ACT-1:0]   enabled;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] q_slot;

  assign wr_idx       = slot[IDX_W-1:0];
  assign stat.slot_ok = ({1'b0, slot} < (SLOT_W + 1)'(ACT));

  always_comb begin
    wbox.x4 = pos_x[9:2];
    wbox.y  = pos_y;
    wbox.w  = width_units;
    wbox.h  = height_rows;
    wbox.bx = border_x;
    wbox.by = border_y;
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_place) begin
      mem[wr_idx] <= wbox;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= '0;
    end else if (ctl.wr_place) begin
      enabled[wr_idx] <= 1'b1;
    end else if (ctl.wr_remove) begin
      enabled[wr_idx] <= 1'b0;
    end
  end

  // read address: query slot first, then the scan index fetched ahead of idx
  always_comb begin
    priority if (ctl.read_q) begin
      rd_addr = q_slot;
    end else if (ctl.load_q) begin
      rd_addr = '0;
    end else if (ctl.step) begin
      rd_addr = IDX_W'(idx + IDX_W'(1));
    end else begin
      rd_addr = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start_query) begin
      q_slot <= slot[IDX_W-1:0];
    end
    if (ctl.load_q) begin
      idx <= '0;
    end else if (ctl.step) begin
      idx <= IDX_W'(idx + IDX_W'(1));
    end
  end

  // queried box with its extents worked out once per query
  logic signed [CW-1:0] qx, qy, qr, qb, qx_in, qy_in, qr_in, qb_in;
  logic                 q_nobrd;

  always_ff @(posedge clk) begin
    if (ctl.load_q) begin
      qx      <= CW'({rdata.x4, 2'b00});
      qy      <= CW'(rdata.y);
      qr      <= CW'({rdata.x4, 2'b00}) + CW'({rdata.w, 2'b00}) - CW'(1);
      qb      <= CW'(rdata.y) + CW'(rdata.h) - CW'(1);
      qx_in   <= CW'({rdata.x4, 2'b00}) + CW'(rdata.bx);
      qy_in   <= CW'(rdata.y) + CW'(rdata.by);
      qr_in   <= CW'({rdata.x4, 2'b00}) + CW'({rdata.w, 2'b00}) - CW'(1) - CW'(rdata.bx);
      qb_in   <= CW'(rdata.y) + CW'(rdata.h) - CW'(1) - CW'(rdata.by);
      q_nobrd <= (rdata.bx == 4'd0) && (rdata.by == 4'd0);
    end
  end

  // overlap test of the queried box against the scanned box
  logic signed [CW-1:0] sx, sy, sr, sb, sx_in, sy_in, sr_in, sb_in;
  logic                 ov_plain, ov_x, ov_y, overlap, nobrd;

  always_comb begin
    sx       = CW'({rdata.x4, 2'b00});
    sy       = CW'(rdata.y);
    sr       = CW'({rdata.x4, 2'b00}) + CW'({rdata.w, 2'b00}) - CW'(1);
    sb       = CW'(rdata.y) + CW'(rdata.h) - CW'(1);
    sx_in    = sx + CW'(rdata.bx);
    sy_in    = sy + CW'(rdata.by);
    sr_in    = sr - CW'(rdata.bx);
    sb_in    = sb - CW'(rdata.by);
    nobrd    = q_nobrd && (rdata.bx == 4'd0) && (rdata.by == 4'd0);
    ov_plain = !((qx > sr) || (sx > qr) || (qy > sb) || (sy > qb));
    ov_x     = (qx >= sx) ? (qx_in <= sr_in) : (sx_in <= qr_in);
    ov_y     = (qy >= sy) ? (qy_in <= sb_in) : (sy_in <= qb_in);
    overlap  = nobrd ? ov_plain : (ov_x && ov_y);
  end

  assign stat.cand     = enabled[idx] && (idx != q_slot) && overlap;
  assign stat.idx_last = (idx == IDX_LAST);

  // hit held back until the next hit or the end of the scan decides its last mark
  logic             pend_valid;
  logic [IDX_W-1:0] pend_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (ctl.load_q) begin
      pend_valid <= 1'b0;
    end else if (ctl.take_hit) begin
      pend_valid <= 1'b1;
    end
    if (ctl.take_hit) begin
      pend_slot <= idx;
    end
  end

  assign stat.pend_valid = pend_valid;

  // class of the pending slot from the boundaries, checked in order
  logic [CFG_W-1:0]   pend_s;
  logic [CLASS_W-1:0] cls_raw;
  logic [CLASS_W-1:0] pend_class;

  always_comb begin
    pend_s = CFG_W'(pend_slot);
    priority if (pend_s < c1_start) begin
      cls_raw = CLASS_W'(0);
    end else if (pend_s < c2_start) begin
      cls_raw = CLASS_W'(1);
    end else if (pend_s < c3_start) begin
      cls_raw = CLASS_W'(2);
    end else if (pend_s < c4_start) begin
      cls_raw = CLASS_W'(3);
    end else begin
      cls_raw = CLASS_W'(4);
    end
    pend_class = (cls_raw > MAX_CLASS) ? MAX_CLASS : cls_raw;
  end

  // output register
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit_pend || ctl.emit_last || ctl.emit_none) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (ctl.emit_pend || ctl.emit_last) begin
      hit_slot   <= SLOT_W'(pend_slot);
      hit_class  <= pend_class;
      none_found <= 1'b0;
      last       <= ctl.emit_last;
    end else if (ctl.emit_none) begin
      hit_slot   <= '0;
      hit_class  <= '0;
      none_found <= 1'b1;
      last       <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sprite_bounding_box_collision.sv -----
// Sprite bounding box collision table, top level.
// Input channel (in_valid/in_ready) takes one command per transaction: place stores a
// slot's box and enables it, remove disables it, query tests one slot's box against
// every other enabled slot. Place and remove can be accepted back to back.
// A query holds the input channel while it reads the queried box from the single read
// port of the slot table, loads its extents, steps the compare unit through every
// slot (NUM_SLOTS, capped at 16) and closes the run. A hit enters the output register
// when the next overlapping slot is taken; the final hit or a none mark enters it when
// the run is closed.
// Output channel (out_valid/out_ready) gives hits in ascending slot order with their
// class; the final transaction carries last, and a query with no overlap gives one
// transaction with none_found and last set. One hit is held back until the next hit
// or the end of the scan; when the receiver stalls, the scan waits on the next hit.
// The configuration port writes class boundaries; the user must write them only while
// the block is idle, which the block does not enforce. Reset clears all enables and
// restores the default class boundaries; slot contents are undefined until placed.
`default_nettype none

module sprite_bounding_box_collision #(
  parameter int NUM_SLOTS   = 16,
  parameter int NUM_CLASSES = 5
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire  [sbbc_pkg::CFG_A_W-1:0]  cfg_addr,
  input  wire  [sbbc_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [sbbc_pkg::CMD_W-1:0]    command,
  input  wire  [sbbc_pkg::SLOT_W-1:0]   slot,
  input  wire  [9:0]                    pos_x,
  input  wire  [8:0]                    pos_y,
  input  wire  [5:0]                    width_units,
  input  wire  [7:0]                    height_rows,
  input  wire  [3:0]                    border_x,
  input  wire  [3:0]                    border_y,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [sbbc_pkg::SLOT_W-1:0]   hit_slot,
  output logic [sbbc_pkg::CLASS_W-1:0]  hit_class,
  output logic                          none_found,
  output logic                          last
);
  import sbbc_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  // sequencing
  sbbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .stat     (stat),
    .ctl      (ctl)
  );

  // table, compare and output
  sbbc_datapath #(
    .NUM_SLOTS   (NUM_SLOTS),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .slot        (slot),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .width_units (width_units),
    .height_rows (height_rows),
    .border_x    (border_x),
    .border_y    (border_y),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .hit_slot    (hit_slot),
    .hit_class   (hit_class),
    .none_found  (none_found),
    .last        (last)
  );

endmodule

`default_nettype wire

// ----- rtl/sbbc_checker.sv -----
// port-level checker for the sprite bounding box collision block, with its bind
`default_nettype none

module sbbc_checker #(
  parameter int NUM_SLOTS   = 16,
  parameter int NUM_CLASSES = 5
) (
  input wire                           clk,
  input wire                           rst,
  input wire                           in_valid,
  input wire                           in_ready,
  input wire [sbbc_pkg::CMD_W-1:0]     command,
  input wire [sbbc_pkg::SLOT_W-1:0]    slot,
  input wire                           out_valid,
  input wire                           out_ready,
  input wire [sbbc_pkg::SLOT_W-1:0]    hit_slot,
  input wire [sbbc_pkg::CLASS_W-1:0]   hit_class,
  input wire                           none_found,
  input wire                           last
);
  import sbbc_pkg::*;

  localparam int ACT = (NUM_SLOTS < SLOT_SPACE) ? NUM_SLOTS : SLOT_SPACE;
  localparam logic [CLASS_W-1:0] MAX_CLASS = CLASS_W'(NUM_CLASSES - 1);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit_slot) && $stable(hit_class)
      && $stable(none_found) && $stable(last))
    else $error("output changed while stalled");

  // a none mark closes the run and carries no slot
  a_none_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && none_found |-> last && (hit_slot == '0) && (hit_class == '0))
    else $error("malformed none mark");

  // class never exceeds the configured class count
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hit_class <= MAX_CLASS)
    else $error("class out of range");

  // a valid query holds off further commands
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (command == CMD_QUERY) && ({1'b0, slot} < (SLOT_W + 1)'(ACT))
      |=> !in_ready)
    else $error("command accepted during a query");

  // no new command while a query run is still open
  a_run_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input ready before the run ended");

endmodule

bind sprite_bounding_box_collision sbbc_checker #(
  .NUM_SLOTS   (NUM_SLOTS),
  .NUM_CLASSES (NUM_CLASSES)
) u_sbbc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .command    (command),
  .slot       (slot),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .hit_slot   (hit_slot),
  .hit_class  (hit_class),
  .none_found (none_found),
  .last       (last)
);

`default_nettype wire

// ----- tb/tb_sprite_bounding_box_collision.sv -----
// self-checking testbench for the sprite bounding box collision table
`timescale 1ns / 1ps

module tb_sprite_bounding_box_collision;
  import sbbc_pkg::*;

  // command code the block ignores
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // idle time after the last result before the block counts as idle
  localparam int SETTLE_CYCLES = 32;
  // receiver hold-off that backs the block up into its input
  localparam int HOLD_CYCLES   = 300;
  // cycles without any transaction before the run is declared hung
  localparam int STUCK_LIMIT   = 3000;
  localparam int PHASE_ITEMS   = 38;

  // one command as driven on the input channel
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] slot;
    logic [9:0]        pos_x;
    logic [8:0]        pos_y;
    logic [5:0]        width_units;
    logic [7:0]        height_rows;
    logic [3:0]        border_x;
    logic [3:0]        border_y;
  } cmd_item_t;

  // one result as seen on the output channel
  typedef struct packed {
    logic [SLOT_W-1:0]  hit_slot;
    logic [CLASS_W-1:0] hit_class;
    logic               none_found;
    logic               last;
  } sprite_hit_t;

  // directed row: command, whether the result is typed in, and that result
  typedef struct packed {
    cmd_item_t   it;
    logic        typed_in;
    sprite_hit_t typed;
  } dir_row_t;

  localparam sprite_hit_t NO_HIT    = '{4'd0, 3'd0, 1'b1, 1'b1};
  localparam sprite_hit_t PREDICTED = '{4'd0, 3'd0, 1'b0, 1'b0};

  // directed stimulus, walked in order under the reset class boundaries
  localparam dir_row_t DIRECTED [22] = '{
    '{'{CMD_PLACE,  4'd0,  10'd0,    9'd0,   6'd0,  8'd0,   4'd0,  4'd0},  1'b0, PREDICTED},
    '{'{CMD_QUERY,  4'd0,  10'd0,    9'd0,   6'd0,  8'd0,   4'd0,  4'd0},  1'b1, NO_HIT},
    '{'{CMD_PLACE,  4'd15, 10'd1023, 9'd511, 6'd63, 8'd255, 4'd15, 4'd15}, 1'b0, PREDICTED},
    '{'{CMD_QUERY,  4'd15, 10'd0,    9'd0,   6'd0,  8'd0,   4'd0,  4'd0},  1'b1, NO_HIT},
    '{'{CMD_QUERY,  4'd0,  10'd0,    9'd0,   6'd0,  8'd0,   4'd0,  4'd0},  1'b1, NO_HIT},
    '{'{CMD_PLACE,  4'd1,  10'd3,    9'd0,   6'd4,  8'd16,  4'd0,  4'd0},  1'b0, PREDICTED},
    '{'{CMD_PLACE,  4'd2,  10'd8,    9'd8,   6'd2,  8'd4,   4'd0,  4'd0},  1'b0, PREDICTED},
    '{'{CMD_QUERY,  4'd1,  10'd0,    9'd0,   6'd0,  8'd0,   4'd0,  4'd0},  1'b0, PREDICTED},
    '{'{CMD_QUERY,  4'd2,  10'd0,    9'd0,   6'd0,  8'd0,   4'd0,  4'd0},  1'b0, PREDICTED},
    '{'{CMD_PLACE,  4'd14, 10'd4,    9'd4,   6'd3,  8'd6,   4'd1,  4'd2},  1'b0, PREDICTED},
    '{'{CMD_PLACE,  4'd13, 10'd4,    9'd4,   6'd1,  8'd1,   4'd0,  4'd0},  1'b0, PREDICTED},
    '{'{CMD_QUERY,  4'd13, 10'd0,    9'd0,   6'd0,  8'd0,   4'd0,  4'd0},  1'b0, PREDICTED},
    '{'{CMD_QUERY,  4'd14, 10'd0,    9'd0,   6'd0,  8'd0,   4'd0,  4'd0},  1'b0, PREDICTED},
    '{'{CMD_UNUSED, 4'd5,  10'd1023, 9'd511, 6'd63, 8'd255, 4'd15, 4'd15}, 1'b0, PREDICTED},
    '{'{CMD_REMOVE, 4'd2,  10'd0,    9'd0,   6'd0,  8'd0,   4'd0,  4'd0},  1'b0, PREDICTED},
    '{'{CMD_QUERY,  4'd1,  10'd0,    9'd0,   6'd0,  8'd0,   4'd0,  4'd0},  1'b0, PREDICTED},
    '{'{CMD_QUERY,  4'd2,  10'd0,    9'd0,   6'd0,  8'd0,   4'd0,  4'd0},  1'b0, PREDICTED},
    '{'{CMD_REMOVE, 4'd7,  10'd0,    9'd0,   6'd0,  8'd0,   4'd0,  4'd0},  1'b0, PREDICTED},
    '{'{CMD_PLACE,  4'd8,  10'd0,    9'd0,   6'd63, 8'd255, 4'd0,  4'd0},  1'b0, PREDICTED},
    '{'{CMD_QUERY,  4'd8,  10'd0,    9'd0,   6'd0,  8'd0,   4'd0,  4'd0},  1'b0, PREDICTED},
    '{'{CMD_PLACE,  4'd12, 10'd1016, 9'd500, 6'd2,  8'd11,  4'd3,  4'd0},  1'b0, PREDICTED},
    '{'{CMD_QUERY,  4'd12, 10'd0,    9'd0,   6'd0,  8'd0,   4'd0,  4'd0},  1'b0, PREDICTED}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_we    = 1'b0;
  logic [CFG_A_W-1:0]   cfg_addr  = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     command     = '0;
  logic [SLOT_W-1:0]    slot        = '0;
  logic [9:0]           pos_x       = '0;
  logic [8:0]           pos_y       = '0;
  logic [5:0]           width_units = '0;
  logic [7:0]           height_rows = '0;
  logic [3:0]           border_x    = '0;
  logic [3:0]           border_y    = '0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SLOT_W-1:0]    hit_slot;
  logic [CLASS_W-1:0]   hit_class;
  logic                 none_found;
  logic                 last;

  // shadow copy of the slot table and class boundaries
  logic [CFG_W-1:0] bounds [4];
  logic             tbl_enabled [SLOT_SPACE];
  logic             ever_placed [SLOT_SPACE];
  logic [9:0]       tbl_x  [SLOT_SPACE];
  logic [8:0]       tbl_y  [SLOT_SPACE];
  logic [5:0]       tbl_w  [SLOT_SPACE];
  logic [7:0]       tbl_h  [SLOT_SPACE];
  logic [3:0]       tbl_bx [SLOT_SPACE];
  logic [3:0]       tbl_by [SLOT_SPACE];

  sprite_hit_t hits_due [$];
  int          mismatches   = 0;
  int          stuck_cycles = 0;
  bit          calm         = 1'b0;
  bit          hold_off_req = 1'b0;
  bit          hold_done    = 1'b0;

  sprite_bounding_box_collision i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .slot        (slot),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .width_units (width_units),
    .height_rows (height_rows),
    .border_x    (border_x),
    .border_y    (border_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit_slot    (hit_slot),
    .hit_class   (hit_class),
    .none_found  (none_found),
    .last        (last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // box overlap test, queried slot a against slot b
  function automatic bit boxes_overlap(input int a, input int b);
    int xa, xb, ya, yb, bxa, bxb, bya, byb, ra, rb, ba, bb;
    xa  = tbl_x[a];
    xb  = tbl_x[b];
    ya  = tbl_y[a];
    yb  = tbl_y[b];
    bxa = tbl_bx[a];
    bxb = tbl_bx[b];
    bya = tbl_by[a];
    byb = tbl_by[b];
    ra  = xa + 4 * int'(tbl_w[a]) - 1;
    rb  = xb + 4 * int'(tbl_w[b]) - 1;
    ba  = ya + int'(tbl_h[a]) - 1;
    bb  = yb + int'(tbl_h[b]) - 1;
    // no borders anywhere: plain extent test
    if ((bxa | bxb | bya | byb) == 0)
      return !(xa > rb || xb > ra || ya > bb || yb > ba);
    // with borders: the later origin (queried slot on a tie) against the other extent
    if (xa >= xb) begin
      if (xa + bxa > rb - bxb) return 1'b0;
    end else if (xb + bxb > ra - bxa) begin
      return 1'b0;
    end
    if (ya >= yb) return (ya + bya <= bb - byb);
    return (yb + byb <= ba - bya);
  endfunction

  // class from the boundaries, compared in register order
  function automatic logic [CLASS_W-1:0] class_of_slot(input int s);
    if (s < int'(bounds[0])) return 3'd0;
    if (s < int'(bounds[1])) return 3'd1;
    if (s < int'(bounds[2])) return 3'd2;
    if (s < int'(bounds[3])) return 3'd3;
    return 3'd4;
  endfunction

  // update the shadow table and queue the hits a command produces
  function automatic void update_sprite_table(input cmd_item_t it, input bit typed_in,
                                              input sprite_hit_t typed);
    sprite_hit_t found [$];
    sprite_hit_t h;
    int          q;
    q = it.slot;
    case (it.command)
      CMD_PLACE: begin
        tbl_x[q]       = it.pos_x & 10'h3FC;
        tbl_y[q]       = it.pos_y;
        tbl_w[q]       = it.width_units;
        tbl_h[q]       = it.height_rows;
        tbl_bx[q]      = it.border_x;
        tbl_by[q]      = it.border_y;
        tbl_enabled[q] = 1'b1;
        ever_placed[q] = 1'b1;
      end
      CMD_REMOVE: tbl_enabled[q] = 1'b0;
      CMD_QUERY: begin
        for (int i = 0; i < SLOT_SPACE; i++) begin
          if (i != q && tbl_enabled[i] && boxes_overlap(q, i)) begin
            h = '{SLOT_W'(i), class_of_slot(i), 1'b0, 1'b0};
            found.push_back(h);
          end
        end
        if (found.size() == 0) begin
          found.push_back(NO_HIT);
        end else begin
          h = found.pop_back();
          h.last = 1'b1;
          found.push_back(h);
        end
        if (typed_in) begin
          hits_due.push_back(typed);
        end else begin
          foreach (found[k]) hits_due.push_back(found[k]);
        end
      end
      default: ;
    endcase
  endfunction

  // random command, mostly clustered boxes so that overlaps are common
  function automatic cmd_item_t random_item(input bit want_query);
    cmd_item_t it;
    int        roll;
    int        placed [$];
    roll = $urandom_range(0, 99);
    if (want_query || roll < 40) it.command = CMD_QUERY;
    else if (roll < 80)          it.command = CMD_PLACE;
    else if (roll < 94)          it.command = CMD_REMOVE;
    else                         it.command = CMD_UNUSED;
    it.slot = SLOT_W'($urandom_range(0, 15));
    if ($urandom_range(0, 4) == 0) begin
      it.pos_x       = 10'($urandom_range(0, 1023));
      it.pos_y       = 9'($urandom_range(0, 511));
      it.width_units = 6'($urandom_range(0, 63));
      it.height_rows = 8'($urandom_range(0, 255));
    end else begin
      it.pos_x       = 10'($urandom_range(0, 255));
      it.pos_y       = 9'($urandom_range(0, 127));
      it.width_units = 6'($urandom_range(0, 16));
      it.height_rows = 8'($urandom_range(0, 48));
    end
    if ($urandom_range(0, 1) == 0) begin
      it.border_x = 4'd0;
      it.border_y = 4'd0;
    end else begin
      it.border_x = 4'($urandom_range(0, 15));
      it.border_y = 4'($urandom_range(0, 15));
    end
    // queries only target slots that hold a stored box
    if (it.command == CMD_QUERY && !ever_placed[it.slot]) begin
      for (int i = 0; i < SLOT_SPACE; i++)
        if (ever_placed[i]) placed.push_back(i);
      if (placed.size() == 0) it.command = CMD_PLACE;
      else it.slot = SLOT_W'(placed[$urandom_range(0, placed.size() - 1)]);
    end
    return it;
  endfunction

  // offer one command, with an optional gap, and wait for its transaction
  task automatic send_item(input cmd_item_t it, input bit typed_in, input sprite_hit_t typed);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    command     <= it.command;
    slot        <= it.slot;
    pos_x       <= it.pos_x;
    pos_y       <= it.pos_y;
    width_units <= it.width_units;
    height_rows <= it.height_rows;
    border_x    <= it.border_x;
    border_y    <= it.border_y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    update_sprite_table(it, typed_in, typed);
  endtask

  // stop offering, wait for every outstanding hit, then let the block go idle
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all four class boundaries
  task automatic set_bounds(input logic [CFG_W-1:0] b1, input logic [CFG_W-1:0] b2,
                            input logic [CFG_W-1:0] b3, input logic [CFG_W-1:0] b4);
    logic [CFG_A_W-1:0] index [4];
    logic [CFG_W-1:0]   value [4];
    index = '{REG_CLASS1_START, REG_CLASS2_START, REG_CLASS3_START, REG_CLASS4_START};
    value = '{b1, b2, b3, b4};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_addr  <= index[i];
      cfg_wdata <= value[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    bounds = value;
  endtask

  task automatic run_random(input int count);
    repeat (count) send_item(random_item(1'b0), 1'b0, PREDICTED);
  endtask

  // main sequence
  initial begin
    bounds = '{CLASS1_RESET, CLASS2_RESET, CLASS3_RESET, CLASS4_RESET};
    for (int i = 0; i < SLOT_SPACE; i++) begin
      tbl_enabled[i] = 1'b0;
      ever_placed[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part on reset boundaries
    foreach (DIRECTED[k])
      send_item(DIRECTED[k].it, DIRECTED[k].typed_in, DIRECTED[k].typed);

    // every slot in the top class
    settle_idle();
    set_bounds(5'd0, 5'd0, 5'd0, 5'd0);
    run_random(PHASE_ITEMS);

    // every slot in class 0, with a long receiver hold-off over a run of queries
    settle_idle();
    set_bounds(5'd16, 5'd16, 5'd16, 5'd16);
    hold_off_req = 1'b1;
    repeat (6) send_item(random_item(1'b1), 1'b0, PREDICTED);
    run_random(PHASE_ITEMS);

    // unordered boundaries
    settle_idle();
    set_bounds(5'd10, 5'd3, 5'd16, 5'd5);
    run_random(PHASE_ITEMS);

    // random boundaries
    settle_idle();
    set_bounds(5'($urandom_range(0, 16)), 5'($urandom_range(0, 16)),
               5'($urandom_range(0, 16)), 5'($urandom_range(0, 16)));
    run_random(PHASE_ITEMS);

    // ordered boundaries, no idling on either side
    settle_idle();
    set_bounds(5'd2, 5'd5, 5'd9, 5'd12);
    calm = 1'b1;
    run_random(PHASE_ITEMS);

    settle_idle();
    if (mismatches == 0) begin
      $display("sprite_bounding_box_collision test passed");
    end else begin
      $display("sprite_bounding_box_collision test failed");
    end
    $finish;
  end

  // receiver: random stall bursts, one long hold-off, always ready at the end
  initial begin
    @(negedge clk);
    forever begin
      if (hold_off_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // compare each output transaction with the oldest expected hit
  always @(posedge clk) begin
    sprite_hit_t want;
    if (!rst && out_valid && out_ready) begin
      if (hits_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual slot %0d class %0d none %0b last %0b",
                 $time, hit_slot, hit_class, none_found, last);
        mismatches++;
      end else begin
        want = hits_due.pop_front();
        check_field("hit_slot",   want.hit_slot,   hit_slot);
        check_field("hit_class",  want.hit_class,  hit_class);
        check_field("none_found", want.none_found, none_found);
        check_field("last",       want.last,       last);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
      $display("sprite_bounding_box_collision test failed");
      $finish;
    end
  end

endmodule

// ----- files.f -----
rtl/sbbc_pkg.sv
rtl/sbbc_ctrl.sv
rtl/sbbc_datapath.sv
rtl/sprite_bounding_box_collision.sv
rtl/sbbc_checker.sv
tb/tb_sprite_bounding_box_collision.sv
